// ----- rtl/core/q2e_pkg.sv -----
// q2e_pkg: shared types, widths and the cordic angle table for quaternion_to_euler
// used by q2e_atan2 and quaternion_to_euler; depends on nothing else
`timescale 1ns / 1ps

package q2e_pkg;

  // operand width of the atan2 inputs (covers +-2^33 with margin)
  localparam int OPW = 35;
  // cordic datapath width, values stay below 2^43 in magnitude
  localparam int CW = 46;
  // normalization target: largest operand lands in [2^40, 2^41)
  localparam int NORM_TOP = 41;
  localparam int CORDIC_STEPS = 24;
  localparam int SQRT_STEPS = 32;
  // atan2 unit latency: prep, two normalize stages, cordic, rounding
  localparam int AT_LAT = 3 + CORDIC_STEPS + 1;
  // pitch prep registers after the sums: square, subtract, square root
  localparam int SIDE_DLY = 2 + SQRT_STEPS;

  localparam logic [15:0] QUARTER_TURN = 16'd16384;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               attitude_ok;
  } euler_t;

  // data that rides alongside the square root pipeline
  typedef struct packed {
    logic                  zero;
    logic                  sat;
    logic                  sgn;
    logic signed [OPW-1:0] roll_y;
    logic signed [OPW-1:0] roll_x;
    logic signed [OPW-1:0] yaw_y;
    logic signed [OPW-1:0] yaw_x;
    logic [31:0]           a_val;
  } side_t;

  // flags that ride alongside the atan2 units
  typedef struct packed {
    logic zero;
    logic sat;
    logic sgn;
  } flag_t;

  // sign extend a product to operand width
  function automatic logic signed [OPW-1:0] sx32(input logic signed [31:0] p);
    sx32 = {{(OPW-32){p[31]}}, p};
  endfunction

endpackage

// ----- rtl/core/q2e_atan2.sv -----
// q2e_atan2: pipelined fixed-point atan2 (normalize, 24 cordic steps, round)
// depends on q2e_pkg
`timescale 1ns / 1ps

module q2e_atan2 (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [q2e_pkg::OPW-1:0]  y_in,
  input  logic signed [q2e_pkg::OPW-1:0]  x_in,
  output logic [15:0]                     angle
);

  localparam int CW = q2e_pkg::CW;
  localparam int NS = q2e_pkg::CORDIC_STEPS;

  // prep stage: fold left half plane
  logic signed [CW-1:0] xe, ye, px, py;
  logic [CW-1:0]        pay;
  logic                 pneg;

  logic signed [CW-1:0] ax_r, ay_r;
  logic [CW-1:0]        aab_r;
  logic [31:0]          az_r;
  logic                 azero_r;

  always_comb begin
    xe   = {{(CW-q2e_pkg::OPW){x_in[q2e_pkg::OPW-1]}}, x_in};
    ye   = {{(CW-q2e_pkg::OPW){y_in[q2e_pkg::OPW-1]}}, y_in};
    pneg = x_in[q2e_pkg::OPW-1];
    px   = pneg ? -xe : xe;
    py   = pneg ? -ye : ye;
    pay  = py[CW-1] ? -py : py;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r    <= px;
      ay_r    <= py;
      aab_r   <= pay;
      az_r    <= pneg ? 32'h8000_0000 : 32'h0;
      azero_r <= (x_in == '0) && (y_in == '0);
    end
  end

  // normalize, coarse shifts by 32, 16, 8
  logic signed [CW-1:0] bx, by;
  logic [CW-1:0]        bm;
  logic signed [CW-1:0] bx_r, by_r;
  logic [CW-1:0]        bm_r;
  logic [31:0]          bz_r;
  logic                 bzero_r;

  always_comb begin
    bx = ax_r;
    by = ay_r;
    bm = ax_r | aab_r;
    for (int j = 0; j < 3; j++) begin
      if (bm < (CW'(1) << (q2e_pkg::NORM_TOP - (32 >> j)))) begin
        bx = bx <<< (32 >> j);
        by = by <<< (32 >> j);
        bm = bm << (32 >> j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bx_r    <= bx;
      by_r    <= by;
      bm_r    <= bm;
      bz_r    <= az_r;
      bzero_r <= azero_r;
    end
  end

  // normalize, fine shifts by 4, 2, 1
  logic signed [CW-1:0] cxn, cyn;
  logic [CW-1:0]        cmn;

  always_comb begin
    cxn = bx_r;
    cyn = by_r;
    cmn = bm_r;
    for (int j = 0; j < 3; j++) begin
      if (cmn < (CW'(1) << (q2e_pkg::NORM_TOP - (4 >> j)))) begin
        cxn = cxn <<< (4 >> j);
        cyn = cyn <<< (4 >> j);
        cmn = cmn << (4 >> j);
      end
    end
  end

  // cordic vectoring stages
  logic signed [CW-1:0] cx_r [0:NS];
  logic signed [CW-1:0] cy_r [0:NS];
  logic [31:0]          cz_r [0:NS];
  logic                 czero_r [0:NS];
  logic signed [CW-1:0] cx_nxt [0:NS-1];
  logic signed [CW-1:0] cy_nxt [0:NS-1];
  logic [31:0]          cz_nxt [0:NS-1];

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      if (cy_r[i] > 0) begin
        cx_nxt[i] = cx_r[i] + (cy_r[i] >>> i);
        cy_nxt[i] = cy_r[i] - (cx_r[i] >>> i);
        cz_nxt[i] = cz_r[i] + q2e_pkg::ATAN_TAB[i];
      end else begin
        cx_nxt[i] = cx_r[i] - (cy_r[i] >>> i);
        cy_nxt[i] = cy_r[i] + (cx_r[i] >>> i);
        cz_nxt[i] = cz_r[i] - q2e_pkg::ATAN_TAB[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r[0]    <= cxn;
      cy_r[0]    <= cyn;
      cz_r[0]    <= bz_r;
      czero_r[0] <= bzero_r;
      for (int i = 0; i < NS; i++) begin
        cx_r[i+1]    <= cx_nxt[i];
        cy_r[i+1]    <= cy_nxt[i];
        cz_r[i+1]    <= cz_nxt[i];
        czero_r[i+1] <= czero_r[i];
      end
    end
  end

  // round the 32-bit angle to 16 bits
  logic [31:0] zround;
  logic [15:0] angle_r;

  assign zround = cz_r[NS] + 32'h0000_8000;

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= czero_r[NS] ? 16'h0 : zround[31:16];
    end
  end

  assign angle = angle_r;

endmodule

// ----- rtl/core/quaternion_to_euler.sv -----
// quaternion_to_euler: top level, products, sums, pitch square root, three atan2 units
// depends on q2e_pkg and q2e_atan2
`timescale 1ns / 1ps

// Converts a Q2.14 quaternion to ZYX roll, pitch and yaw binary angles (value times
// pi/32768 radians), normalization folded into the arithmetic. One transaction is
// taken every cycle while in_ready is high, that is while the skid register is
// empty. The depth comes from the 32-stage bit-serial square root on the pitch
// path followed by the 28-stage cordic atan2 units; roll and yaw operands wait in
// a delay line alongside the square root. An all-zero quaternion gives
// attitude_ok low and zero angles. The pipeline halts only when both the output
// register and the skid register hold results.
module quaternion_to_euler (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  q2e_pkg::quat_t  in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output q2e_pkg::euler_t out_item
);

  localparam int OPW = q2e_pkg::OPW;
  localparam int SD  = q2e_pkg::SIDE_DLY;
  localparam int AL  = q2e_pkg::AT_LAT;
  localparam int SS  = q2e_pkg::SQRT_STEPS;

  logic en;
  logic skid_v_r, out_v_r;
  q2e_pkg::euler_t skid_r, out_r, res;

  assign en       = !skid_v_r;
  assign in_ready = en;

  // input register
  logic           t0_v_r;
  q2e_pkg::quat_t t0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t0_r <= in_item;
    end
  end

  // products
  logic                t1_v_r;
  logic signed [31:0]  p_xx_r, p_yy_r, p_zz_r, p_ww_r, p_wx_r;
  logic signed [31:0]  p_yz_r, p_wz_r, p_xy_r, p_wy_r, p_zx_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_xx_r <= t0_r.quat_x * t0_r.quat_x;
      p_yy_r <= t0_r.quat_y * t0_r.quat_y;
      p_zz_r <= t0_r.quat_z * t0_r.quat_z;
      p_ww_r <= t0_r.quat_w * t0_r.quat_w;
      p_wx_r <= t0_r.quat_w * t0_r.quat_x;
      p_yz_r <= t0_r.quat_y * t0_r.quat_z;
      p_wz_r <= t0_r.quat_w * t0_r.quat_z;
      p_xy_r <= t0_r.quat_x * t0_r.quat_y;
      p_wy_r <= t0_r.quat_w * t0_r.quat_y;
      p_zx_r <= t0_r.quat_z * t0_r.quat_x;
    end
  end

  // norm and the atan2 / asin operands
  logic                  t2_v_r;
  logic signed [OPW-1:0] n_r, ry_r, rx_r, yy_r, yx_r, sp_r;
  logic signed [OPW-1:0] xx, yy, zz, ww, n_sum;

  always_comb begin
    xx    = q2e_pkg::sx32(p_xx_r);
    yy    = q2e_pkg::sx32(p_yy_r);
    zz    = q2e_pkg::sx32(p_zz_r);
    ww    = q2e_pkg::sx32(p_ww_r);
    n_sum = xx + yy + zz + ww;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r  <= n_sum;
      ry_r <= (q2e_pkg::sx32(p_wx_r) + q2e_pkg::sx32(p_yz_r)) <<< 1;
      rx_r <= n_sum - ((xx + yy) <<< 1);
      yy_r <= (q2e_pkg::sx32(p_wz_r) + q2e_pkg::sx32(p_xy_r)) <<< 1;
      yx_r <= n_sum - ((yy + zz) <<< 1);
      sp_r <= (q2e_pkg::sx32(p_wy_r) - q2e_pkg::sx32(p_zx_r)) <<< 1;
    end
  end

  // pitch prep: magnitude, saturation test, halving of large norms
  logic signed [OPW-1:0] a_abs;
  logic                  halve;
  logic [OPW-1:0]        nn_w, aa_w;
  logic [31:0]           nn_r;
  q2e_pkg::side_t        side_nxt;

  always_comb begin
    a_abs = sp_r[OPW-1] ? -sp_r : sp_r;
    halve = (n_r[OPW-1:32] != '0);
    nn_w  = halve ? (n_r >> 1) : n_r;
    aa_w  = halve ? (a_abs >> 1) : a_abs;
    side_nxt.zero   = (n_r == '0);
    side_nxt.sat    = (a_abs >= n_r);
    side_nxt.sgn    = sp_r[OPW-1];
    side_nxt.roll_y = ry_r;
    side_nxt.roll_x = rx_r;
    side_nxt.yaw_y  = yy_r;
    side_nxt.yaw_x  = yx_r;
    side_nxt.a_val  = aa_w[31:0];
  end

  // side delay line alongside the square root
  logic           sd_v_r [0:SD];
  q2e_pkg::side_t side_r [0:SD];

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      nn_r      <= nn_w[31:0];
      for (int k = 0; k < SD; k++) begin
        side_r[k+1] <= side_r[k];
      end
    end
  end

  // squares of the cosine leg terms
  logic [63:0] sqn_r, sqa_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sqn_r <= nn_r * nn_r;
      sqa_r <= side_r[0].a_val * side_r[0].a_val;
    end
  end

  // bit-serial square root, one result bit per stage
  logic [63:0] sv_r [0:SS];
  logic [63:0] sr_r [0:SS];
  logic [63:0] sv_nxt [0:SS-1];
  logic [63:0] sr_nxt [0:SS-1];
  logic [63:0] sbit, strial;

  always_comb begin
    sbit   = '0;
    strial = '0;
    for (int j = 0; j < SS; j++) begin
      sbit   = 64'(1) << (2 * (SS - 1 - j));
      strial = sr_r[j] + sbit;
      if (sv_r[j] >= strial) begin
        sv_nxt[j] = sv_r[j] - strial;
        sr_nxt[j] = (sr_r[j] >> 1) + sbit;
      end else begin
        sv_nxt[j] = sv_r[j];
        sr_nxt[j] = sr_r[j] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sv_r[0] <= sqn_r - sqa_r;
      sr_r[0] <= '0;
      for (int j = 0; j < SS; j++) begin
        sv_r[j+1] <= sv_nxt[j];
        sr_r[j+1] <= sr_nxt[j];
      end
    end
  end

  // three atan2 units, fed in the same cycle
  logic signed [OPW-1:0] pa_y, pa_x;
  logic [15:0]           roll_ang, yaw_ang, pitch_ang;

  assign pa_y = {{(OPW-32){1'b0}}, side_r[SD].a_val};
  assign pa_x = {{(OPW-32){1'b0}}, sr_r[SS][31:0]};

  q2e_atan2 u_roll (
    .clk   (clk),
    .en    (en),
    .y_in  (side_r[SD].roll_y),
    .x_in  (side_r[SD].roll_x),
    .angle (roll_ang)
  );

  q2e_atan2 u_yaw (
    .clk   (clk),
    .en    (en),
    .y_in  (side_r[SD].yaw_y),
    .x_in  (side_r[SD].yaw_x),
    .angle (yaw_ang)
  );

  q2e_atan2 u_pitch (
    .clk   (clk),
    .en    (en),
    .y_in  (pa_y),
    .x_in  (pa_x),
    .angle (pitch_ang)
  );

  // flag delay line alongside the atan2 units
  logic           fl_v_r [0:AL-1];
  q2e_pkg::flag_t fl_r [0:AL-1];

  always_ff @(posedge clk) begin
    if (en) begin
      fl_r[0].zero <= side_r[SD].zero;
      fl_r[0].sat  <= side_r[SD].sat;
      fl_r[0].sgn  <= side_r[SD].sgn;
      for (int k = 0; k < AL - 1; k++) begin
        fl_r[k+1] <= fl_r[k];
      end
    end
  end

  // valid bits for every stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_v_r <= 1'b0;
      t1_v_r <= 1'b0;
      t2_v_r <= 1'b0;
      for (int k = 0; k <= SD; k++) begin
        sd_v_r[k] <= 1'b0;
      end
      for (int k = 0; k < AL; k++) begin
        fl_v_r[k] <= 1'b0;
      end
    end else if (en) begin
      t0_v_r    <= in_valid;
      t1_v_r    <= t0_v_r;
      t2_v_r    <= t1_v_r;
      sd_v_r[0] <= t2_v_r;
      for (int k = 0; k < SD; k++) begin
        sd_v_r[k+1] <= sd_v_r[k];
      end
      fl_v_r[0] <= sd_v_r[SD];
      for (int k = 0; k < AL - 1; k++) begin
        fl_v_r[k+1] <= fl_v_r[k];
      end
    end
  end

  // result assembly: saturation, sign and the zero quaternion
  logic [15:0] pitch_mag;

  always_comb begin
    pitch_mag = fl_r[AL-1].sat ? q2e_pkg::QUARTER_TURN : pitch_ang;
    if (fl_r[AL-1].zero) begin
      res = '0;
    end else begin
      res.roll_angle  = roll_ang;
      res.yaw_angle   = yaw_ang;
      res.pitch_angle = fl_r[AL-1].sgn ? (16'h0 - pitch_mag) : pitch_mag;
      res.attitude_ok = 1'b1;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_ready || !out_v_r) begin
      out_v_r  <= skid_v_r || (en && fl_v_r[AL-1]);
      skid_v_r <= 1'b0;
    end else if (en && fl_v_r[AL-1]) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_v_r) begin
      out_r <= skid_v_r ? skid_r : res;
    end else if (en && fl_v_r[AL-1]) begin
      skid_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  // skid stage holds data only behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register valid while output register empty");

  // a zero quaternion transaction carries zero angles
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_r.attitude_ok) |->
      (out_r.roll_angle == 16'sd0 && out_r.pitch_angle == 16'sd0 &&
       out_r.yaw_angle == 16'sd0))
    else $error("invalid attitude with nonzero angles");

  // pitch stays within a quarter turn
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_r.pitch_angle <= 16'sd16384 && out_r.pitch_angle >= -16'sd16384))
    else $error("pitch beyond a quarter turn");
`endif

endmodule
